// ----- rtl/core/cfde_pkg.sv -----
// ----------------------------------------------------------------------------
// cfde_pkg: shared types and codes of the clipped framebuffer draw engine
// Holds the command opcodes, the pixel and coordinate types and a helper that
// widens a 16-bit signed field to the internal coordinate width.
// ----------------------------------------------------------------------------
`default_nettype none

package cfde_pkg;

  localparam int CoordWidth = 18;

  typedef logic [2:0]                   opcode_t;
  typedef logic [15:0]                  pixel_t;
  typedef logic signed [15:0]           field_t;
  typedef logic signed [CoordWidth-1:0] coord_t;

  localparam opcode_t OP_FILL    = 3'd0;
  localparam opcode_t OP_OUTLINE = 3'd1;
  localparam opcode_t OP_BEGIN   = 3'd2;
  localparam opcode_t OP_PIXEL   = 3'd3;
  localparam opcode_t OP_READ    = 3'd4;

  function automatic coord_t widen(input field_t v);
    return coord_t'(v);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cfde_if.sv -----
// ----------------------------------------------------------------------------
// cfde_if: command and response channels of the draw engine
// Valid/ready channels; one transfer happens at a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfde_cmd_if;
  logic               valid;
  logic               ready;
  cfde_pkg::opcode_t  operation;
  cfde_pkg::field_t   x_pos;
  cfde_pkg::field_t   y_pos;
  cfde_pkg::field_t   width;
  cfde_pkg::field_t   height;
  cfde_pkg::pixel_t   color;

  modport source (output valid, operation, x_pos, y_pos, width, height, color,
                  input ready);
  modport sink   (input valid, operation, x_pos, y_pos, width, height, color,
                  output ready);
endinterface

interface cfde_rsp_if;
  logic              valid;
  logic              ready;
  cfde_pkg::pixel_t  pixel_value;
  logic              on_screen;

  modport source (output valid, pixel_value, on_screen, input ready);
  modport sink   (input valid, pixel_value, on_screen, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/clipped_framebuffer_draw_engine.sv -----
// ----------------------------------------------------------------------------
// clipped_framebuffer_draw_engine: RGB565 framebuffer with clipped drawing
// Owns a SCREEN_COLUMNS x SCREEN_ROWS framebuffer and runs drawing commands.
//
// Channels: cmd takes one command per transfer (fill, outline, bitmap begin,
// bitmap pixel, read). rsp returns one pixel and an on-screen flag per read;
// no other command gives a response.
// Throughput: one command at a time; cmd.ready is high only while idle.
// All pixel work goes through one sequencer with one framebuffer write port:
//   bitmap begin, non-positive sizes, ignored bitmap pixels, unused codes: accept
//   bitmap pixel: accept, setup, row base, write (accept, setup if off screen)
//   fill: accept, setup, row base, one write per pixel (accept, setup if clipped)
//   outline: accept, then per border side a setup step, plus row base and its
//     pixels if on screen
//   read: accept, setup, row base, RAM read, result (no RAM steps if off screen)
// A finished read waits in the rsp register; the block keeps taking commands
// and only a second read stalls until that result is taken.
// Reset: rst clears the command state, then a clearing pass writes zero to
// every pixel with cmd.ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_framebuffer_draw_engine #(
  parameter int SCREEN_COLUMNS = 480,
  parameter int SCREEN_ROWS    = 272
) (
  input wire logic    clk,
  input wire logic    rst,
  cfde_cmd_if.sink    cmd,
  cfde_rsp_if.source  rsp
);

  import cfde_pkg::*;

  localparam int DEPTH = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
  localparam int YW    = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;

  localparam logic [AW-1:0] COLS_A    = AW'(SCREEN_COLUMNS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam coord_t        XMAX      = coord_t'(SCREEN_COLUMNS - 1);
  localparam coord_t        YMAX      = coord_t'(SCREEN_ROWS - 1);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_BASE  = 3'd3;
  localparam logic [2:0] S_RUN   = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [1:0] KIND_FILL    = 2'd0;
  localparam logic [1:0] KIND_OUTLINE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam logic [1:0] SEG_TOP    = 2'd0;
  localparam logic [1:0] SEG_BOTTOM = 2'd1;
  localparam logic [1:0] SEG_LEFT   = 2'd2;
  localparam logic [1:0] SEG_RIGHT  = 2'd3;

  logic [2:0]    state;
  logic [AW-1:0] clr_addr;
  logic [1:0]    kind;
  logic [1:0]    seg;
  coord_t        cx, cy, cr, cb;
  pixel_t        fill_color;
  logic [XW-1:0] px, xa, xb;
  logic [YW-1:0] py, yb;
  logic [AW-1:0] row_base;
  logic          hit;

  field_t        blit_origin_x, blit_origin_y, blit_width, blit_height;
  logic [15:0]   blit_column, blit_row;

  logic          res_valid;
  pixel_t        res_value;
  logic          res_on;
  logic          res_load;

  coord_t        sa, sb, ta, tb, xa_c, xb_c, ya_c, yb_c;
  logic          skip, empty, last_seg, blit_live;
  logic [15:0]   col_inc;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, pix_addr;
  pixel_t        ram_wdata, ram_rdata;

  // Box of the current segment, clipped to the screen.
  always_comb begin
    case (seg)
      SEG_TOP: begin
        sa = cx; sb = cr; ta = cy; tb = (kind == KIND_OUTLINE) ? cy : cb;
      end
      SEG_BOTTOM: begin
        sa = cx; sb = cr; ta = cb; tb = cb;
      end
      SEG_LEFT: begin
        sa = cx; sb = cx; ta = cy; tb = cb;
      end
      default: begin
        sa = cr; sb = cr; ta = cy; tb = cb;
      end
    endcase
    skip = (kind == KIND_OUTLINE) &&
           (((seg == SEG_BOTTOM) && (cb == cy)) || ((seg == SEG_RIGHT) && (cr == cx)));
    xa_c     = sa[CoordWidth-1] ? '0 : sa;
    ya_c     = ta[CoordWidth-1] ? '0 : ta;
    xb_c     = (sb > XMAX) ? XMAX : sb;
    yb_c     = (tb > YMAX) ? YMAX : tb;
    empty    = skip || (xa_c > xb_c) || (ya_c > yb_c);
    last_seg = (kind != KIND_OUTLINE) || (seg == SEG_RIGHT);
  end

  assign blit_live = (blit_width > 0) && (blit_height > 0) &&
                     ($signed(blit_row) < blit_height);
  assign col_inc   = blit_column + 16'd1;
  assign pix_addr  = row_base + AW'(px);
  assign res_load  = (state == S_OUT) && (!res_valid || rsp.ready);

  assign cmd.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_addr      <= '0;
      res_valid     <= 1'b0;
      blit_origin_x <= '0;
      blit_origin_y <= '0;
      blit_width    <= '0;
      blit_height   <= '0;
      blit_column   <= '0;
      blit_row      <= '0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            seg <= SEG_TOP;
            case (cmd.operation)
              OP_FILL, OP_OUTLINE: begin
                if ((cmd.width > 0) && (cmd.height > 0)) begin
                  cx         <= widen(cmd.x_pos);
                  cy         <= widen(cmd.y_pos);
                  cr         <= widen(cmd.x_pos) + widen(cmd.width) - coord_t'(1);
                  cb         <= widen(cmd.y_pos) + widen(cmd.height) - coord_t'(1);
                  fill_color <= cmd.color;
                  kind       <= (cmd.operation == OP_OUTLINE) ? KIND_OUTLINE : KIND_FILL;
                  state      <= S_SETUP;
                end
              end
              OP_BEGIN: begin
                blit_origin_x <= cmd.x_pos;
                blit_origin_y <= cmd.y_pos;
                blit_width    <= cmd.width;
                blit_height   <= cmd.height;
                blit_column   <= '0;
                blit_row      <= '0;
              end
              OP_PIXEL: begin
                if (blit_live) begin
                  cx         <= widen(blit_origin_x) + coord_t'(blit_column);
                  cr         <= widen(blit_origin_x) + coord_t'(blit_column);
                  cy         <= widen(blit_origin_y) + coord_t'(blit_row);
                  cb         <= widen(blit_origin_y) + coord_t'(blit_row);
                  fill_color <= cmd.color;
                  kind       <= KIND_FILL;
                  state      <= S_SETUP;
                  if ($signed(col_inc) >= blit_width) begin
                    blit_column <= '0;
                    blit_row    <= blit_row + 16'd1;
                  end else begin
                    blit_column <= col_inc;
                  end
                end
              end
              OP_READ: begin
                cx    <= widen(cmd.x_pos);
                cr    <= widen(cmd.x_pos);
                cy    <= widen(cmd.y_pos);
                cb    <= widen(cmd.y_pos);
                kind  <= KIND_READ;
                state <= S_SETUP;
              end
              default: begin
              end
            endcase
          end
        end
        S_SETUP: begin
          if (empty) begin
            if (kind == KIND_READ) begin
              hit   <= 1'b0;
              state <= S_OUT;
            end else if (last_seg) begin
              state <= S_IDLE;
            end else begin
              seg <= seg + 2'd1;
            end
          end else begin
            px    <= XW'(xa_c);
            xa    <= XW'(xa_c);
            xb    <= XW'(xb_c);
            py    <= YW'(ya_c);
            yb    <= YW'(yb_c);
            state <= S_BASE;
          end
        end
        S_BASE: begin
          row_base <= AW'(py) * COLS_A;
          state    <= (kind == KIND_READ) ? S_RD : S_RUN;
        end
        S_RUN: begin
          if (px == xb) begin
            if (py == yb) begin
              if (last_seg) begin
                state <= S_IDLE;
              end else begin
                seg   <= seg + 2'd1;
                state <= S_SETUP;
              end
            end else begin
              py       <= py + YW'(1);
              row_base <= row_base + COLS_A;
              px       <= xa;
            end
          end else begin
            px <= px + XW'(1);
          end
        end
        S_RD: begin
          hit   <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_load) begin
            res_value <= hit ? ram_rdata : '0;
            res_on    <= hit;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    ram_we    = (state == S_CLR) || (state == S_RUN);
    ram_waddr = (state == S_CLR) ? clr_addr : pix_addr;
    ram_wdata = (state == S_CLR) ? '0 : fill_color;
    ram_re    = (state == S_RD);
  end

  cfde_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (pix_addr),
    .rdata (ram_rdata)
  );

  assign rsp.valid       = res_valid;
  assign rsp.pixel_value = res_value;
  assign rsp.on_screen   = res_on;

endmodule

`default_nettype wire

// ----- rtl/core/cfde_ram.sv -----
// ----------------------------------------------------------------------------
// cfde_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cfde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cfde_checker.sv -----
// ----------------------------------------------------------------------------
// cfde_checker: port-level checks of the draw engine
// Watches the command and response channels and flags protocol or
// sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module cfde_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cmd_valid,
  input wire logic               cmd_ready,
  input wire cfde_pkg::opcode_t  cmd_operation,
  input wire cfde_pkg::field_t   cmd_width,
  input wire cfde_pkg::field_t   cmd_height,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire cfde_pkg::pixel_t   rsp_pixel_value,
  input wire logic               rsp_on_screen
);

  import cfde_pkg::*;

  logic cmd_xfer;
  assign cmd_xfer = cmd_valid && cmd_ready;

  a_reset_clears: assert property (@(posedge clk) rst |=> !cmd_ready)
    else $error("command channel ready right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_value) &&
                                  $stable(rsp_on_screen))
    else $error("stalled response changed");

  a_off_screen_zero: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && !rsp_on_screen |-> rsp_pixel_value == '0)
    else $error("off-screen read returned nonzero pixel");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
      cmd_xfer && (cmd_operation == OP_READ) |=> !cmd_ready)
    else $error("read transfer did not occupy the engine");

  a_fill_busy: assert property (@(posedge clk) disable iff (rst)
      cmd_xfer && (cmd_operation == OP_FILL) && (cmd_width > 0) && (cmd_height > 0)
      |=> !cmd_ready)
    else $error("nonempty fill did not occupy the engine");

endmodule

bind clipped_framebuffer_draw_engine cfde_checker u_cfde_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .cmd_operation   (cmd.operation),
  .cmd_width       (cmd.width),
  .cmd_height      (cmd.height),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_pixel_value (rsp.pixel_value),
  .rsp_on_screen   (rsp.on_screen)
);

`default_nettype wire
